// ===== hw/rtl/trbp_pkg.sv =====
`default_nettype none

package trbp_pkg;

  // table geometry
  localparam int LC_ENTRIES = 65536;
  localparam int LH_ENTRIES = 8192;
  localparam int GL_ENTRIES = 16384;
  localparam int CTR_BITS   = 2;
  localparam int PC_SHIFT   = 2;
  localparam int PC_W       = 64;

  localparam int LC_W = $clog2(LC_ENTRIES);
  localparam int LH_W = $clog2(LH_ENTRIES);
  localparam int GL_W = $clog2(GL_ENTRIES);

  // clearing sweep covers the deepest table
  localparam int CLR_ENTRIES = (LC_ENTRIES > LH_ENTRIES) ?
                               ((LC_ENTRIES > GL_ENTRIES) ? LC_ENTRIES : GL_ENTRIES) :
                               ((LH_ENTRIES > GL_ENTRIES) ? LH_ENTRIES : GL_ENTRIES);
  localparam int CLR_W = $clog2(CLR_ENTRIES);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CTR_BITS-1:0] ctr_t;

  // one classified branch waiting for the back end
  typedef struct packed {
    logic [LH_W-1:0] hidx;
    logic            taken;
  } q_item_t;

  // back end status and control toward the front
  typedef struct packed {
    logic clearing;
    logic pop;
  } bk_ctl_t;

  // saturating counter step toward the outcome
  function automatic ctr_t ctr_bump(input ctr_t c, input logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != {CTR_BITS{1'b1}}) r = c + ctr_t'(1);
    end else begin
      if (c != '0) r = c - ctr_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tournament_branch_predictor_top.sv =====
`default_nettype none

// Tournament branch predictor trained by resolved branches. An item (pc, taken)
// is taken when start is high and busy is low; its result (predicted_taken,
// correct) appears on the ports for one cycle with done high, after the back
// end picks the item from its two-entry queue and steps through S_HIST and
// S_CTR, and cannot be held off. The back end runs each item as a history read,
// a counter read and a training write on single-port tables, and takes a new
// item only once it is through with the last; with an idle back end up to three
// items can be taken back to back before busy rises. After reset a clearing
// sweep zeroes all tables, one entry per table per cycle, over the depth of the
// deepest table, with busy high.
module tournament_branch_predictor_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [trbp_pkg::PC_W-1:0]  pc,
  input  wire logic                       taken,
  output logic                            busy,
  output logic                            done,
  output logic                            predicted_taken,
  output logic                            correct
);

  trbp_pkg::bk_ctl_t   bk_ctl;
  trbp_pkg::q_item_t   q_item;
  logic                q_valid;

  // front: accept and classify items, hold them in the queue
  trbp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .pc      (pc),
    .taken   (taken),
    .bk_ctl  (bk_ctl),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // back: predict, train and report
  trbp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .bk_ctl          (bk_ctl),
    .done            (done),
    .predicted_taken (predicted_taken),
    .correct         (correct)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/trbp_front.sv =====
`default_nettype none

module trbp_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [trbp_pkg::PC_W-1:0]    pc,
  input  wire logic                         taken,
  input  wire trbp_pkg::bk_ctl_t            bk_ctl,
  output logic                              busy,
  output logic                              q_valid,
  output trbp_pkg::q_item_t                 q_item
);

  trbp_pkg::q_item_t                          slots [trbp_pkg::QUEUE_DEPTH];
  logic [trbp_pkg::QPTR_W-1:0]                wr_ptr;
  logic [trbp_pkg::QPTR_W-1:0]                rd_ptr;
  logic [trbp_pkg::QCNT_W-1:0]                count;
  logic                                       push;
  trbp_pkg::q_item_t                          new_item;

  // accept while room and no clearing sweep
  assign busy = bk_ctl.clearing ||
                (count == trbp_pkg::QCNT_W'(trbp_pkg::QUEUE_DEPTH));
  assign push = start && !busy;

  // classify: word address picks the local history entry
  always_comb begin
    new_item.hidx  = pc[trbp_pkg::PC_SHIFT +: trbp_pkg::LH_W];
    new_item.taken = taken;
  end

  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == trbp_pkg::QPTR_W'(trbp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + trbp_pkg::QPTR_W'(1);
      end
      if (bk_ctl.pop) begin
        rd_ptr <= (rd_ptr == trbp_pkg::QPTR_W'(trbp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + trbp_pkg::QPTR_W'(1);
      end
      if (push && !bk_ctl.pop) begin
        count <= count + trbp_pkg::QCNT_W'(1);
      end else if (!push && bk_ctl.pop) begin
        count <= count - trbp_pkg::QCNT_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trbp_back.sv =====
`default_nettype none

module trbp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire trbp_pkg::q_item_t    q_item,
  output trbp_pkg::bk_ctl_t         bk_ctl,
  output logic                      done,
  output logic                      predicted_taken,
  output logic                      correct
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HIST  = 4'b0010,
    S_CTR   = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [trbp_pkg::CLR_W-1:0]     clr_cnt;
  logic [trbp_pkg::GL_W-1:0]      path_hist;
  logic [trbp_pkg::LH_W-1:0]      cur_hidx;
  logic                           cur_taken;

  // tables
  logic [trbp_pkg::LC_W-1:0]      lh_mem [trbp_pkg::LH_ENTRIES];
  trbp_pkg::ctr_t                 lc_mem [trbp_pkg::LC_ENTRIES];
  trbp_pkg::ctr_t                 gc_mem [trbp_pkg::GL_ENTRIES];
  trbp_pkg::ctr_t                 ch_mem [trbp_pkg::GL_ENTRIES];

  // registered read data
  logic [trbp_pkg::LC_W-1:0]      hist_rd;
  trbp_pkg::ctr_t                 lc_rd;
  trbp_pkg::ctr_t                 gc_rd;
  trbp_pkg::ctr_t                 ch_rd;

  logic                           clearing;
  logic                           pop;
  logic                           upd;
  logic                           lguess;
  logic                           gguess;
  logic                           guess;

  logic                           lh_we;
  logic [trbp_pkg::LH_W-1:0]      lh_wa;
  logic [trbp_pkg::LC_W-1:0]      lh_wd;
  logic                           lc_we;
  logic [trbp_pkg::LC_W-1:0]      lc_wa;
  trbp_pkg::ctr_t                 lc_wd;
  logic                           gc_we;
  logic [trbp_pkg::GL_W-1:0]      gc_wa;
  trbp_pkg::ctr_t                 gc_wd;
  logic                           ch_we;
  trbp_pkg::ctr_t                 ch_wd;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && q_valid;
  assign upd      = (state == S_CTR);

  always_comb begin
    bk_ctl.clearing = clearing;
    bk_ctl.pop      = pop;
  end

  // guesses from the counters read for the current item
  assign lguess = lc_rd[trbp_pkg::CTR_BITS-1];
  assign gguess = gc_rd[trbp_pkg::CTR_BITS-1];
  assign guess  = ch_rd[trbp_pkg::CTR_BITS-1] ? gguess : lguess;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == trbp_pkg::CLR_W'(trbp_pkg::CLR_ENTRIES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) state_next = S_HIST;
      end
      S_HIST:  state_next = S_CTR;
      S_CTR:   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // control registers, path history and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      path_hist <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= upd;
      if (clearing) begin
        clr_cnt <= clr_cnt + trbp_pkg::CLR_W'(1);
      end
      if (upd) begin
        path_hist <= {path_hist[trbp_pkg::GL_W-2:0], cur_taken};
      end
    end
  end

  // item payload and result values
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_hidx  <= q_item.hidx;
      cur_taken <= q_item.taken;
    end
    if (upd) begin
      predicted_taken <= guess;
      correct         <= (guess == cur_taken);
    end
  end

  // write ports: clearing sweep or training of the current item
  always_comb begin
    lh_we = clearing || upd;
    lh_wa = clearing ? clr_cnt[trbp_pkg::LH_W-1:0] : cur_hidx;
    lh_wd = clearing ? '0 : {hist_rd[trbp_pkg::LC_W-2:0], cur_taken};
    lc_we = clearing || upd;
    lc_wa = clearing ? clr_cnt[trbp_pkg::LC_W-1:0] : hist_rd;
    lc_wd = clearing ? '0 : trbp_pkg::ctr_bump(lc_rd, cur_taken);
    gc_we = clearing || upd;
    gc_wa = clearing ? clr_cnt[trbp_pkg::GL_W-1:0] : path_hist;
    gc_wd = clearing ? '0 : trbp_pkg::ctr_bump(gc_rd, cur_taken);
    ch_we = clearing || (upd && (lguess != gguess));
    ch_wd = clearing ? '0 : trbp_pkg::ctr_bump(ch_rd, gguess == cur_taken);
  end

  // local history table
  always_ff @(posedge clk) begin
    if (lh_we) begin
      lh_mem[lh_wa] <= lh_wd;
    end
    if (pop) begin
      hist_rd <= lh_mem[q_item.hidx];
    end
  end

  // local pattern counters
  always_ff @(posedge clk) begin
    if (lc_we) begin
      lc_mem[lc_wa] <= lc_wd;
    end
    if (state == S_HIST) begin
      lc_rd <= lc_mem[hist_rd];
    end
  end

  // global pattern counters
  always_ff @(posedge clk) begin
    if (gc_we) begin
      gc_mem[gc_wa] <= gc_wd;
    end
    if (state == S_HIST) begin
      gc_rd <= gc_mem[path_hist];
    end
  end

  // chooser counters
  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[gc_wa] <= ch_wd;
    end
    if (state == S_HIST) begin
      ch_rd <= ch_mem[path_hist];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trbp_checker.sv =====
`default_nettype none

module trbp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // reset starts the clearing sweep, which holds items off
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // no result in the cycle after reset
  a_no_done_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result right after reset");

  // results are spaced by each item's pass through S_IDLE, S_HIST and S_CTR
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done ##1 !done)
    else $error("results closer than three cycles");

  // an accepted item is answered after at most one item ahead in the back end
  // and one in the queue
  a_accept_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##[4:8] done)
    else $error("no result within eight cycles of an accept");

endmodule

bind tournament_branch_predictor_top trbp_checker u_trbp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
